### sv/obstacle_avoid_gait_sequencer_macros.svh
// ----------------------------------------------------------------------------
// obstacle avoid gait sequencer assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef OBSTACLE_AVOID_GAIT_SEQUENCER_MACROS_SVH
`define OBSTACLE_AVOID_GAIT_SEQUENCER_MACROS_SVH

// same-cycle implication
`define OAGS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("oags check failed");

// next-cycle implication
`define OAGS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("oags check failed");

`endif

### sv/oags_pkg.sv
// ----------------------------------------------------------------------------
// oags_pkg
// codes, pose type and gait tables of the gait sequencer
// ----------------------------------------------------------------------------
package oags_pkg;

	localparam int AngleW = 8;
	localparam int DistW  = 7;
	localparam int ThrW   = 8;
	localparam int StepW  = 4;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_WALK = 3'd1,
		MODE_TURN = 3'd2,
		MODE_BACK = 3'd3,
		MODE_STOP = 3'd4
	} mode_t;

	localparam logic [1:0] KIND_DIST = 2'd0;
	localparam logic [1:0] KIND_TICK = 2'd1;
	localparam logic [1:0] KIND_CMD  = 2'd2;

	localparam logic [2:0] CMD_STOP  = 3'd0;
	localparam logic [2:0] CMD_WALK  = 3'd1;
	localparam logic [2:0] CMD_LEFT  = 3'd2;
	localparam logic [2:0] CMD_RIGHT = 3'd3;
	localparam logic [2:0] CMD_BACK  = 3'd4;

	localparam logic [2:0] ADDR_NEAR = 3'd0;
	localparam logic [2:0] ADDR_WARN = 3'd4;

	localparam logic [ThrW-1:0] NEAR_RESET = 8'd15;
	localparam logic [ThrW-1:0] WARN_RESET = 8'd25;

	localparam logic [StepW-1:0] WALK_LEN   = 4'd6;
	localparam logic [StepW-1:0] TURN_LEN   = 4'd3;
	localparam logic [StepW-1:0] BACK_TOTAL = 4'd8;

	localparam logic [AngleW-1:0] STAND_ANGLE = 8'd90;

	typedef struct packed {
		logic [AngleW-1:0] fl;
		logic [AngleW-1:0] fr;
		logic [AngleW-1:0] rl;
		logic [AngleW-1:0] rr;
	} pose_t;

	localparam pose_t POSE_STAND = '{fl: 8'd90, fr: 8'd90, rl: 8'd90, rr: 8'd90};
	localparam pose_t POSE_A     = '{fl: 8'd70, fr: 8'd90, rl: 8'd90, rr: 8'd70};
	localparam pose_t POSE_B     = '{fl: 8'd110, fr: 8'd90, rl: 8'd90, rr: 8'd110};
	localparam pose_t POSE_C     = '{fl: 8'd90, fr: 8'd70, rl: 8'd70, rr: 8'd90};
	localparam pose_t POSE_D     = '{fl: 8'd90, fr: 8'd110, rl: 8'd110, rr: 8'd90};
	localparam pose_t POSE_E     = '{fl: 8'd120, fr: 8'd60, rl: 8'd60, rr: 8'd120};
	localparam pose_t POSE_F     = '{fl: 8'd60, fr: 8'd120, rl: 8'd120, rr: 8'd60};

	// step mod 6 for a 4-bit step
	function automatic logic [2:0] walk_idx(input logic [StepW-1:0] step);
		logic [StepW-1:0] r;
		if (step < WALK_LEN)
			r = step;
		else if (step < 4'(2 * WALK_LEN))
			r = step - WALK_LEN;
		else
			r = step - 4'(2 * WALK_LEN);
		return r[2:0];
	endfunction

	function automatic pose_t walk_row(input logic [2:0] idx);
		pose_t p;
		unique case (idx)
			3'd0: p = POSE_A;
			3'd1: p = POSE_B;
			3'd3: p = POSE_C;
			3'd4: p = POSE_D;
			default: p = POSE_STAND;
		endcase
		return p;
	endfunction

	function automatic pose_t turn_row(input logic left, input logic [1:0] idx);
		pose_t p;
		unique case (idx)
			2'd0: p = left ? POSE_C : POSE_A;
			2'd1: p = left ? POSE_B : POSE_D;
			default: p = POSE_STAND;
		endcase
		return p;
	endfunction

	function automatic pose_t back_row(input logic [1:0] idx);
		pose_t p;
		unique case (idx)
			2'd0: p = POSE_E;
			2'd2: p = POSE_F;
			default: p = POSE_STAND;
		endcase
		return p;
	endfunction

endpackage

### sv/obstacle_avoid_gait_sequencer.sv
// ----------------------------------------------------------------------------
// obstacle avoid gait sequencer
// mode sequencer and servo pose generator of a four-legged walker
// ----------------------------------------------------------------------------
// a transaction passes the input register, then the result register, to result valid
// throughput: one transaction per cycle unless stalled; mode logic is combinational
// the input register drains whenever the result register is empty or being taken
// reset: async active low; mode idle, step 0, flags 0, thresholds 15 and 25 cm
// reset empties both registers; no clearing pass
module obstacle_avoid_gait_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [6:0]  distance_cm,
	input  logic [2:0]  command,
	input  logic        turn_left_pick,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        servo_write,
	output logic [7:0]  angle_front_left,
	output logic [7:0]  angle_front_right,
	output logic [7:0]  angle_rear_left,
	output logic [7:0]  angle_rear_right,
	output logic [2:0]  mode,
	output logic        obstacle_seen
);

	logic [oags_pkg::ThrW-1:0] near_q, warn_q;

	logic                      valid_s1;
	logic [1:0]                kind_s1;
	logic [oags_pkg::DistW-1:0] dist_s1;
	logic [2:0]                cmd_s1;
	logic                      pick_s1;

	oags_pkg::mode_t            mode_q, mode_d;
	logic [oags_pkg::StepW-1:0] step_q, step_d;
	logic                       left_q, left_d;
	logic                       obst_q, obst_d;
	logic                       wr_d;
	oags_pkg::pose_t            pose_d;
	logic [2:0]                 widx;
	logic [oags_pkg::StepW-1:0] step_inc;

	logic            out_valid_s2;
	logic            wr_s2;
	oags_pkg::pose_t pose_s2;
	oags_pkg::mode_t mode_s2;
	logic            obst_s2;

	logic adv;

	// apb register file
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr)
			oags_pkg::ADDR_NEAR: prdata = {24'd0, near_q};
			oags_pkg::ADDR_WARN: prdata = {24'd0, warn_q};
			default: prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= oags_pkg::NEAR_RESET;
			warn_q <= oags_pkg::WARN_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr == oags_pkg::ADDR_NEAR)
				near_q <= pwdata[7:0];
			if (paddr == oags_pkg::ADDR_WARN)
				warn_q <= pwdata[7:0];
		end
	end

	// handshake
	assign adv      = !out_valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			dist_s1 <= distance_cm;
			cmd_s1  <= command;
			pick_s1 <= turn_left_pick;
		end
	end

	// next state and pose
	assign widx     = oags_pkg::walk_idx(step_q);
	assign step_inc = step_q + 4'd1;

	always_comb begin
		mode_d = mode_q;
		step_d = step_q;
		left_d = left_q;
		obst_d = obst_q;
		wr_d   = 1'b0;
		pose_d = '0;
		unique case (kind_s1)
			oags_pkg::KIND_DIST: begin
				if ({1'b0, dist_s1} < near_q) begin
					obst_d = 1'b1;
					if (mode_q != oags_pkg::MODE_BACK && mode_q != oags_pkg::MODE_TURN) begin
						mode_d = oags_pkg::MODE_BACK;
						step_d = '0;
					end
				end else if ({1'b0, dist_s1} < warn_q) begin
					obst_d = 1'b1;
					if (mode_q == oags_pkg::MODE_WALK) begin
						mode_d = oags_pkg::MODE_TURN;
						step_d = '0;
						left_d = pick_s1;
					end
				end else begin
					obst_d = 1'b0;
					if (mode_q == oags_pkg::MODE_IDLE || mode_q == oags_pkg::MODE_STOP) begin
						mode_d = oags_pkg::MODE_WALK;
						step_d = '0;
					end
				end
			end
			oags_pkg::KIND_TICK: begin
				unique case (mode_q)
					oags_pkg::MODE_WALK: begin
						wr_d   = 1'b1;
						pose_d = oags_pkg::walk_row(widx);
						step_d = (widx == 3'(oags_pkg::WALK_LEN - 4'd1)) ? '0
							: {1'b0, widx + 3'd1};
					end
					oags_pkg::MODE_TURN: begin
						wr_d = 1'b1;
						if (step_q < oags_pkg::TURN_LEN) begin
							pose_d = oags_pkg::turn_row(left_q, step_q[1:0]);
							step_d = step_inc;
						end else begin
							pose_d = oags_pkg::POSE_STAND;
							mode_d = oags_pkg::MODE_WALK;
							step_d = '0;
						end
					end
					oags_pkg::MODE_BACK: begin
						wr_d   = 1'b1;
						pose_d = oags_pkg::back_row(step_q[1:0]);
						if (step_inc >= oags_pkg::BACK_TOTAL) begin
							mode_d = oags_pkg::MODE_TURN;
							step_d = '0;
							left_d = pick_s1;
						end else begin
							step_d = step_inc;
						end
					end
					default: begin
						wr_d   = 1'b1;
						pose_d = oags_pkg::POSE_STAND;
					end
				endcase
			end
			oags_pkg::KIND_CMD: begin
				unique case (cmd_s1)
					oags_pkg::CMD_STOP: begin
						mode_d = oags_pkg::MODE_STOP;
						wr_d   = 1'b1;
						pose_d = oags_pkg::POSE_STAND;
					end
					oags_pkg::CMD_WALK: begin
						mode_d = oags_pkg::MODE_WALK;
						step_d = '0;
					end
					oags_pkg::CMD_LEFT: begin
						mode_d = oags_pkg::MODE_TURN;
						step_d = '0;
						left_d = 1'b1;
					end
					oags_pkg::CMD_RIGHT: begin
						mode_d = oags_pkg::MODE_TURN;
						step_d = '0;
						left_d = 1'b0;
					end
					oags_pkg::CMD_BACK: begin
						mode_d = oags_pkg::MODE_BACK;
						step_d = '0;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= oags_pkg::MODE_IDLE;
			step_q       <= '0;
			left_q       <= 1'b0;
			obst_q       <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= valid_s1;
			if (valid_s1) begin
				mode_q <= mode_d;
				step_q <= step_d;
				left_q <= left_d;
				obst_q <= obst_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			wr_s2   <= wr_d;
			pose_s2 <= pose_d;
			mode_s2 <= mode_d;
			obst_s2 <= obst_d;
		end
	end

	assign out_valid         = out_valid_s2;
	assign servo_write       = wr_s2;
	assign angle_front_left  = pose_s2.fl;
	assign angle_front_right = pose_s2.fr;
	assign angle_rear_left   = pose_s2.rl;
	assign angle_rear_right  = pose_s2.rr;
	assign mode              = mode_s2;
	assign obstacle_seen     = obst_s2;

endmodule

### sv/oags_checker.sv
// ----------------------------------------------------------------------------
// oags_checker
// port-level checks of the gait sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "obstacle_avoid_gait_sequencer_macros.svh"

module oags_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       servo_write,
	input logic [7:0] angle_front_left,
	input logic [7:0] angle_front_right,
	input logic [7:0] angle_rear_left,
	input logic [7:0] angle_rear_right,
	input logic [2:0] mode
);

	logic out_txn;
	assign out_txn = out_valid && !out_stall;

	// a result that is no servo command carries zero angles
	`OAGS_ASSERT_NOW(a_quiet_zero, out_txn && !servo_write, angle_front_left == 8'd0 && angle_front_right == 8'd0 && angle_rear_left == 8'd0 && angle_rear_right == 8'd0)

	// every pose is diagonal-symmetric
	`OAGS_ASSERT_NOW(a_diag_pose, out_txn && servo_write, angle_front_left == angle_rear_right && angle_front_right == angle_rear_left)

	// idle or stopped transaction writes the stand-up pose
	`OAGS_ASSERT_NOW(a_stand_pose, out_txn && servo_write && (mode == oags_pkg::MODE_IDLE || mode == oags_pkg::MODE_STOP), angle_front_left == oags_pkg::STAND_ANGLE && angle_front_right == oags_pkg::STAND_ANGLE)

	// stalled result holds
	`OAGS_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(mode) && $stable(servo_write))

endmodule

bind obstacle_avoid_gait_sequencer oags_checker u_oags_checker (.*);

### tb/tb_obstacle_avoid_gait_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_obstacle_avoid_gait_sequencer
// self-checking bench for the walker mode sequencer: a scoreboard predicts
// mode, obstacle flag and servo pose for every accepted transaction and
// checks results in order, under random valid gaps and output stalls, over
// several threshold settings written through the register port
// ----------------------------------------------------------------------------
module tb_obstacle_avoid_gait_sequencer;
	import oags_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int ItemsPerPhase = 350;

	typedef struct packed {
		logic       wr;
		pose_t      pose;
		logic [2:0] mode;
		logic       obst;
	} gait_result_t;

	class gait_scoreboard;
		logic [7:0]   near_thr;
		logic [7:0]   warn_thr;
		mode_t        mode_q;
		logic [3:0]   step_q;
		logic         left_q;
		logic         obst_q;
		gait_result_t pose_queue[$];
		int           mismatches;

		function new();
			near_thr = NEAR_RESET;
			warn_thr = WARN_RESET;
			mode_q = MODE_IDLE;
			step_q = '0;
			left_q = 1'b0;
			obst_q = 1'b0;
			mismatches = 0;
		endfunction

		function void set_thresholds(logic [7:0] near_v, logic [7:0] warn_v);
			near_thr = near_v;
			warn_thr = warn_v;
		endfunction

		function int pending();
			return pose_queue.size();
		endfunction

		function void report_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t mismatch: %s", $realtime, msg);
		endfunction

		function void note_input(logic [1:0] k, logic [6:0] d, logic [2:0] c, logic p);
			gait_result_t r;
			logic [3:0] idx;
			r = '0;
			case (k)
				KIND_DIST: begin
					if ({1'b0, d} < near_thr) begin
						obst_q = 1'b1;
						if (mode_q != MODE_BACK && mode_q != MODE_TURN) begin
							mode_q = MODE_BACK;
							step_q = '0;
						end
					end else if ({1'b0, d} < warn_thr) begin
						obst_q = 1'b1;
						if (mode_q == MODE_WALK) begin
							mode_q = MODE_TURN;
							step_q = '0;
							left_q = p;
						end
					end else begin
						obst_q = 1'b0;
						if (mode_q == MODE_IDLE || mode_q == MODE_STOP) begin
							mode_q = MODE_WALK;
							step_q = '0;
						end
					end
				end
				KIND_TICK: begin
					case (mode_q)
						MODE_WALK: begin
							idx = step_q % 4'd6;
							r.wr = 1'b1;
							case (idx)
								4'd0: r.pose = POSE_A;
								4'd1: r.pose = POSE_B;
								4'd3: r.pose = POSE_C;
								4'd4: r.pose = POSE_D;
								default: r.pose = POSE_STAND;
							endcase
							step_q = (idx + 4'd1) % 4'd6;
						end
						MODE_TURN: begin
							r.wr = 1'b1;
							if (step_q < 3) begin
								case (step_q)
									4'd0: r.pose = left_q ? POSE_C : POSE_A;
									4'd1: r.pose = left_q ? POSE_B : POSE_D;
									default: r.pose = POSE_STAND;
								endcase
								step_q = step_q + 4'd1;
							end else begin
								mode_q = MODE_WALK;
								step_q = '0;
								r.pose = POSE_STAND;
							end
						end
						MODE_BACK: begin
							r.wr = 1'b1;
							case (step_q[1:0])
								2'd0: r.pose = POSE_E;
								2'd2: r.pose = POSE_F;
								default: r.pose = POSE_STAND;
							endcase
							step_q = step_q + 4'd1;
							if (step_q >= 8) begin
								mode_q = MODE_TURN;
								step_q = '0;
								left_q = p;
							end
						end
						MODE_IDLE, MODE_STOP: begin
							r.wr = 1'b1;
							r.pose = POSE_STAND;
						end
						default: ;
					endcase
				end
				KIND_CMD: begin
					case (c)
						CMD_STOP: begin
							mode_q = MODE_STOP;
							r.wr = 1'b1;
							r.pose = POSE_STAND;
						end
						CMD_WALK: begin
							mode_q = MODE_WALK;
							step_q = '0;
						end
						CMD_LEFT: begin
							mode_q = MODE_TURN;
							step_q = '0;
							left_q = 1'b1;
						end
						CMD_RIGHT: begin
							mode_q = MODE_TURN;
							step_q = '0;
							left_q = 1'b0;
						end
						CMD_BACK: begin
							mode_q = MODE_BACK;
							step_q = '0;
						end
						default: ;
					endcase
				end
				default: ;
			endcase
			r.mode = mode_q;
			r.obst = obst_q;
			pose_queue.push_back(r);
		endfunction

		function void check_result(gait_result_t act);
			gait_result_t exp_r;
			if (pose_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", act));
				return;
			end
			exp_r = pose_queue.pop_front();
			if (act.wr !== exp_r.wr || act.pose.fl !== exp_r.pose.fl
					|| act.pose.fr !== exp_r.pose.fr || act.pose.rl !== exp_r.pose.rl
					|| act.pose.rr !== exp_r.pose.rr || act.mode !== exp_r.mode
					|| act.obst !== exp_r.obst)
				report_mismatch($sformatf(
					"expected wr %b pose %0d/%0d/%0d/%0d mode %0d obst %b, got wr %b pose %0d/%0d/%0d/%0d mode %0d obst %b",
					exp_r.wr, exp_r.pose.fl, exp_r.pose.fr, exp_r.pose.rl, exp_r.pose.rr,
					exp_r.mode, exp_r.obst, act.wr, act.pose.fl, act.pose.fr,
					act.pose.rl, act.pose.rr, act.mode, act.obst));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = '0;
	logic [6:0]  distance_cm = '0;
	logic [2:0]  command = '0;
	logic        turn_left_pick = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        servo_write;
	logic [7:0]  angle_front_left;
	logic [7:0]  angle_front_right;
	logic [7:0]  angle_rear_left;
	logic [7:0]  angle_rear_right;
	logic [2:0]  mode;
	logic        obstacle_seen;

	gait_scoreboard sb = new();
	bit no_idle = 1'b0;
	int cycles = 0;

	obstacle_avoid_gait_sequencer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.distance_cm(distance_cm),
		.command(command),
		.turn_left_pick(turn_left_pick),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.servo_write(servo_write),
		.angle_front_left(angle_front_left),
		.angle_front_right(angle_front_right),
		.angle_rear_left(angle_rear_left),
		.angle_rear_right(angle_rear_right),
		.mode(mode),
		.obstacle_seen(obstacle_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("obstacle_avoid_gait_sequencer verification failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= !no_idle && ($urandom_range(99) < 19);
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_input(kind, distance_cm, command, turn_left_pick);
		if (arst_n && out_valid && !out_stall)
			sb.check_result({servo_write, angle_front_left, angle_front_right,
				angle_rear_left, angle_rear_right, mode, obstacle_seen});
	end

	task automatic send_item(logic [1:0] k, logic [6:0] d, logic [2:0] c, logic p);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		distance_cm <= d;
		command <= c;
		turn_left_pick <= p;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid and let every result come out before touching registers
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [7:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {24'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {24'd0, value})
			sb.report_mismatch($sformatf("register %0d read %h, wrote %h", addr, prdata, value));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_thresholds(logic [7:0] near_v, logic [7:0] warn_v);
		drain();
		write_reg(ADDR_NEAR, near_v);
		write_reg(ADDR_WARN, warn_v);
		sb.set_thresholds(near_v, warn_v);
	endtask

	// aim readings below near, between the thresholds, clear of both, or anywhere
	function automatic logic [6:0] pick_distance(int near_v, int warn_v);
		int sel;
		int lo;
		int hi;
		sel = $urandom_range(3);
		lo = 0;
		hi = 100;
		if (sel == 0 && near_v > 0)
			hi = (near_v > 100) ? 100 : near_v - 1;
		else if (sel == 1 && warn_v > near_v && near_v <= 100) begin
			lo = near_v;
			hi = (warn_v > 101) ? 100 : warn_v - 1;
		end else if (sel == 2 && warn_v <= 100)
			lo = warn_v;
		return 7'($urandom_range(hi, lo));
	endfunction

	task automatic random_phase(int count);
		int done;
		int roll;
		logic [6:0] d;
		logic [2:0] c;
		logic p;
		done = 0;
		while (done < count) begin
			roll = $urandom_range(99);
			d = 7'($urandom_range(100));
			c = 3'($urandom_range(7));
			p = 1'($urandom_range(1));
			if (roll < 50) begin
				send_item(KIND_TICK, d, c, p);
				done++;
			end else if (roll < 80) begin
				send_item(KIND_DIST, pick_distance(int'(sb.near_thr), int'(sb.warn_thr)),
					c, p);
				done++;
			end else if (roll < 92) begin
				send_item(KIND_CMD, d, 3'($urandom_range(CMD_BACK)), p);
				done++;
			end else if (roll < 96) begin
				send_item(2'd3, d, c, p);
			end else begin
				send_item(KIND_CMD, d, 3'($urandom_range(7, 5)), p);
			end
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed: default thresholds 15 and 25
		send_item(2'd3, 7'd100, 3'd7, 1'b1);
		send_item(KIND_TICK, 7'd0, CMD_STOP, 1'b0);
		send_item(KIND_DIST, 7'd100, CMD_STOP, 1'b0);
		repeat (6) send_item(KIND_TICK, 7'd127, 3'd7, 1'b1);
		send_item(KIND_DIST, 7'd20, CMD_STOP, 1'b1);
		repeat (4) send_item(KIND_TICK, 7'd0, CMD_STOP, 1'b0);
		send_item(KIND_DIST, 7'd0, CMD_STOP, 1'b0);
		send_item(KIND_CMD, 7'd0, 3'd7, 1'b0);
		send_item(KIND_CMD, 7'd0, CMD_STOP, 1'b0);
		send_item(KIND_TICK, 7'd0, CMD_STOP, 1'b0);
		send_item(KIND_CMD, 7'd64, CMD_LEFT, 1'b0);
		send_item(KIND_CMD, 7'd64, CMD_RIGHT, 1'b1);
		send_item(KIND_CMD, 7'd64, CMD_BACK, 1'b0);
		send_item(KIND_CMD, 7'd64, CMD_WALK, 1'b0);
		send_item(KIND_DIST, 7'd15, CMD_STOP, 1'b0);

		random_phase(ItemsPerPhase);
		set_thresholds(8'd40, 8'd70);
		random_phase(ItemsPerPhase);
		set_thresholds(8'd0, 8'd0);
		random_phase(ItemsPerPhase / 2);
		set_thresholds(8'd60, 8'd30);
		no_idle = 1'b1;
		random_phase(ItemsPerPhase);
		no_idle = 1'b0;
		set_thresholds(8'd255, 8'd255);
		random_phase(ItemsPerPhase / 2);
		set_thresholds(8'd0, 8'd255);
		random_phase(ItemsPerPhase);

		drain();
		repeat (6) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("obstacle_avoid_gait_sequencer verification clean");
		else
			$display("obstacle_avoid_gait_sequencer verification failed");
		$finish;
	end

endmodule
